@@ design/slri_pkg.sv @@
package slri_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_RESULT
   } slri_state_type;

   // request kinds carried in req_tuser
   localparam logic [1:0] MODE_INSERT     = 2'd0;
   localparam logic [1:0] MODE_REMOVE_ONE = 2'd1;
   localparam logic [1:0] MODE_REMOVE_ALL = 2'd2;

   // result status carried in rsp_tuser
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam int COUNT_OUT_WIDTH = 5;
   localparam int DATA_OUT_WIDTH  = 32;

   // broadcast to every cell of the row
   typedef struct packed {
      logic ins;   // open a slot at the insert point, shift the tail up
      logic del;   // close the slot at the first equal entry, shift the tail down
   } slri_cmd_type;

endpackage

@@ design/slri_cell.sv @@
module slri_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  slri_pkg::slri_cmd_type        cmd,
   input  logic signed [VALUE_WIDTH-1:0] value,
   input  logic signed [VALUE_WIDTH-1:0] left_entry,
   input  logic signed [VALUE_WIDTH-1:0] right_entry,
   input  logic                          left_lt,
   input  logic                          occupied,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output logic                          lt,
   output logic                          eq
);
   import slri_pkg::*;

   logic signed [VALUE_WIDTH-1:0] entry_ff;
   logic signed [VALUE_WIDTH-1:0] entry_in;

   assign lt    = occupied && (entry_ff < value);
   assign eq    = occupied && (entry_ff == value);
   assign entry = entry_ff;

   // cells below the insert or delete point keep their entry
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && !lt) begin
         entry_in = left_lt ? value : left_entry;
      end else if (cmd.del && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ design/sorted_list_insert_remove.sv @@
// Sorted multiset of signed values held in a row of compare-and-shift cells.
// Request channel req_*: req_tuser is the mode (insert, remove one equal
// entry, remove all equal entries), req_tdata the value. Every request gives
// one response beat on rsp_*: rsp_tuser is the status (done, not found, full),
// rsp_tdata the entry count after the request and the smallest entry (0 when
// the store is empty).
// Timing: a request is registered, then all cells compare against it and shift
// together in the work state, and the response register loads in the result
// state, where the next request may already be taken if the output is free.
// Remove-all takes one entry out per cycle through the same cell shift and
// stays in the work state until no equal entry is left.
// Reset (synchronous, active high) empties the store and drops any pending
// response; cell contents are not cleared, the entry count decides which
// cells are live.
// When the receiver stalls, one finished response waits in the output
// register while the next request is worked on; that request then holds in
// its result step until the output register frees up.
module sorted_list_insert_remove #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // entry_count[4:0], smallest[36:5], zero[39:37]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import slri_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   slri_state_type state_ff, state_in;
   logic [1:0]                    mode_ff, mode_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          removed_ff, removed_in;
   logic [1:0]                    status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;
   logic [DATA_OUT_WIDTH-1:0]     rsp_small_ff, rsp_small_in;

   slri_cmd_type cmd;
   logic signed [VALUE_WIDTH-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]           cell_lt;
   logic [CAPACITY-1:0]           cell_eq;
   logic [CAPACITY-1:0]           cell_occ;
   logic                          found;
   logic                          out_free;
   logic                          req_accept;
   logic signed [31:0]            req_value_s;

   assign req_value_s = signed'(req_tdata);
   assign found       = |cell_eq;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) || ((state_ff == ST_RESULT) && out_free);
   assign req_accept  = req_tvalid && req_tready;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] left_entry;
         logic signed [VALUE_WIDTH-1:0] right_entry;
         logic                          left_lt;

         assign cell_occ[gi] = CW'(gi) < count_ff;

         if (gi == 0) begin : g_first
            // nothing on the left: the insert point can be no lower
            assign left_entry = value_ff;
            assign left_lt    = 1'b1;
         end else begin : g_mid
            assign left_entry = cell_entry[gi-1];
            assign left_lt    = cell_lt[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_entry = value_ff;
         end else begin : g_notlast
            assign right_entry = cell_entry[gi+1];
         end

         slri_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .value      (value_ff),
            .left_entry (left_entry),
            .right_entry(right_entry),
            .left_lt    (left_lt),
            .occupied   (cell_occ[gi]),
            .entry      (cell_entry[gi]),
            .lt         (cell_lt[gi]),
            .eq         (cell_eq[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      removed_in    = removed_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_small_in  = rsp_small_ff;
      cmd           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (count_ff == CAP) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.ins   = 1'b1;
                     count_in  = count_ff + 1'b1;
                     status_in = STATUS_DONE;
                  end
                  state_in = ST_RESULT;
               end
               MODE_REMOVE_ONE: begin
                  if (found) begin
                     cmd.del   = 1'b1;
                     count_in  = count_ff - 1'b1;
                     status_in = STATUS_DONE;
                  end else begin
                     status_in = STATUS_NOT_FOUND;
                  end
                  state_in = ST_RESULT;
               end
               MODE_REMOVE_ALL: begin
                  // one equal entry leaves per cycle until none is left
                  if (found) begin
                     cmd.del    = 1'b1;
                     count_in   = count_ff - 1'b1;
                     removed_in = 1'b1;
                  end else begin
                     status_in = removed_ff ? STATUS_DONE : STATUS_NOT_FOUND;
                     state_in  = ST_RESULT;
                  end
               end
               default: begin
                  status_in = STATUS_DONE;
                  state_in  = ST_RESULT;
               end
            endcase
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_OUT_WIDTH'(count_ff);
               rsp_small_in  = (count_ff != '0) ? DATA_OUT_WIDTH'(cell_entry[0]) : '0;
               state_in      = req_accept ? ST_WORK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_accept) begin
         mode_in    = req_tuser;
         value_in   = VALUE_WIDTH'(req_value_s);
         removed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         removed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_small_ff  <= rsp_small_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_small_ff, rsp_count_ff};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import slri_pkg::*;

   localparam int          LIST_DEPTH   = 16;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam int          PHASE_ITEMS  = 425;
   localparam int          DRAIN_CYCLES = 60;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          NUM_ROWS     = 24;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  count;
      logic [31:0] smallest;
   } list_result_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [31:0]     value;
      logic [4:0]      reps;
      logic            typed;
      list_result_type known;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // value[31:0]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // entry_count[4:0], smallest[36:5], zero[39:37]
   logic [1:0]  rsp_tuser;   // status[1:0]

   sorted_list_insert_remove dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   logic signed [31:0] model_entries[$];
   list_result_type    pending_results[$];
   directed_row_type   plan [0:NUM_ROWS-1];
   int                 error_count;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 hold_left;
   bit                 hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sorted multiset update, returns the response the request should give
   function automatic list_result_type apply_request(input logic [1:0] mode,
                                                     input logic signed [31:0] value);
      list_result_type    res;
      logic signed [31:0] kept[$];
      int                 pos;
      res.status = STATUS_DONE;
      pos = 0;
      while (pos < model_entries.size() && model_entries[pos] < value)
         pos++;
      case (mode)
         MODE_INSERT: begin
            if (model_entries.size() >= LIST_DEPTH)
               res.status = STATUS_FULL;
            else
               model_entries.insert(pos, value);
         end
         MODE_REMOVE_ONE: begin
            if (pos < model_entries.size() && model_entries[pos] == value)
               model_entries.delete(pos);
            else
               res.status = STATUS_NOT_FOUND;
         end
         MODE_REMOVE_ALL: begin
            foreach (model_entries[i])
               if (model_entries[i] != value)
                  kept.push_back(model_entries[i]);
            if (kept.size() == model_entries.size())
               res.status = STATUS_NOT_FOUND;
            model_entries = kept;
         end
         default: ;
      endcase
      res.count    = 5'(model_entries.size());
      res.smallest = (model_entries.size() != 0) ? model_entries[0] : 32'd0;
      return res;
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1: v = $urandom;
         2: begin
            case ($urandom_range(3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         3, 4: v = (model_entries.size() != 0) ?
                   model_entries[$urandom_range(model_entries.size() - 1)] : $urandom;
         default: v = 32'($signed($urandom_range(6)) - 3);
      endcase
      return v;
   endfunction

   // offer one request beat, wait for it to be taken, then log the expectation
   task automatic offer_request(input logic [1:0] mode, input logic [31:0] value,
                                input logic typed, input list_result_type known);
      list_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = apply_request(mode, value);
      pending_results.push_back(typed ? known : predicted);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int          done_items;
      int          insert_bias;
      int          r;
      logic [1:0]  mode;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
         // swing between filling and draining so full and empty both recur
         insert_bias = ((done_items / 50) % 2) ? 75 : 20;
         r = $urandom_range(99);
         if (r < 3)
            mode = MODE_UNUSED;
         else if (r < 3 + insert_bias)
            mode = MODE_INSERT;
         else if ($urandom_range(99) < 60)
            mode = MODE_REMOVE_ONE;
         else
            mode = MODE_REMOVE_ALL;
         offer_request(mode, pick_value(), 1'b0, '0);
         if (mode != MODE_UNUSED)
            done_items++;
      end
   endtask

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tuser;
         got.count    = rsp_tdata[4:0];
         got.smallest = rsp_tdata[36:5];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response beat: status %0d count %0d smallest %h",
                        got.status, got.count, got.smallest);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("response mismatch: status %0d/%0d count %0d/%0d smallest %h/%h",
                           want.status, got.status, want.count, got.count,
                           want.smallest, got.smallest);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      error_count    = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      plan = '{
         '{MODE_REMOVE_ONE, 32'd5,         5'd1,  1'b1, '{STATUS_NOT_FOUND, 5'd0, 32'd0}},
         '{MODE_REMOVE_ALL, 32'd5,         5'd1,  1'b1, '{STATUS_NOT_FOUND, 5'd0, 32'd0}},
         '{MODE_UNUSED,     32'hffff_ffff, 5'd1,  1'b1, '{STATUS_DONE, 5'd0, 32'd0}},
         '{MODE_INSERT,     32'h8000_0000, 5'd1,  1'b1, '{STATUS_DONE, 5'd1, 32'h8000_0000}},
         '{MODE_INSERT,     32'h7fff_ffff, 5'd1,  1'b1, '{STATUS_DONE, 5'd2, 32'h8000_0000}},
         '{MODE_REMOVE_ONE, 32'h7fff_ffff, 5'd1,  1'b1, '{STATUS_DONE, 5'd1, 32'h8000_0000}},
         '{MODE_INSERT,     32'h0000_0000, 5'd1,  1'b0, '0},
         '{MODE_INSERT,     32'h0000_0000, 5'd1,  1'b0, '0},
         '{MODE_INSERT,     32'hffff_ffff, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ALL, 32'h0000_0000, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ONE, 32'h8000_0000, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ONE, 32'h8000_0000, 5'd1,  1'b0, '0},
         '{MODE_INSERT,     32'h0000_0007, 5'd15, 1'b0, '0},
         '{MODE_INSERT,     32'h1234_5678, 5'd1,  1'b1, '{STATUS_FULL, 5'd16, 32'hffff_ffff}},
         '{MODE_INSERT,     32'h8000_0000, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ONE, 32'h0000_0007, 5'd1,  1'b0, '0},
         '{MODE_INSERT,     32'h8000_0000, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ALL, 32'h0000_0007, 5'd1,  1'b0, '0},
         '{MODE_UNUSED,     32'h0000_0000, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ALL, 32'hffff_ffff, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ALL, 32'h8000_0000, 5'd1,  1'b1, '{STATUS_DONE, 5'd0, 32'd0}},
         '{MODE_INSERT,     32'haaaa_aaaa, 5'd1,  1'b0, '0},
         '{MODE_INSERT,     32'h5555_5555, 5'd1,  1'b0, '0},
         '{MODE_REMOVE_ALL, 32'h1234_5678, 5'd1,  1'b0, '0}
      };
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         for (int r = 0; r < plan[i].reps; r++)
            offer_request(plan[i].mode, plan[i].value, plan[i].typed, plan[i].known);

      // long receiver hold-off while beats keep coming at full rate
      hold_request = 1'b1;
      run_random_phase(0, 0);
      run_random_phase(54, 0);
      run_random_phase(0, 54);
      run_random_phase(29, 29);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
